/* design/mnag_pkg.sv */
// Package for the masked neighbor average grow block.
// Shared constants and types; no dependencies.
package mnag_pkg;

  localparam int MAX_PADDED_SIDE_D = 1024;
  localparam int SAMPLE_BITS_D     = 16;
  localparam int MAX_CHANNELS_D    = 4;

  localparam int SIDE_W  = 10;
  localparam int CHCNT_W = 3;
  localparam int COUNT_W = 20;
  localparam int OUT_W   = 16;
  localparam int CFG_W   = 10;

  // configuration register indexes
  typedef enum logic {
    REG_IMAGE_SIDE    = 1'b0,
    REG_CHANNEL_COUNT = 1'b1
  } cfg_reg_t;

  // divider sequencer states
  typedef enum logic [1:0] {
    DIV_IDLE = 2'd0,
    DIV_RUN  = 2'd1,
    DIV_DONE = 2'd2
  } div_state_t;

endpackage

/* design/masked_neighbor_average_grow.sv */
// Top level of the masked neighbor average grow block.
// Depends on mnag_pkg, mnag_front, mnag_fifo, mnag_back.
//
// Usage: padded square image of side image_side+2 streams in raster order on
// the in_ channel, one pixel request per beat (tdata: chan0..chan3, 16 bits
// each). For every interior pixel a result request leaves on out_ once the
// pixel below-right of it has arrived. tlast marks the last interior pixel,
// tuser flags a grown pixel.
// The front part holds two padded rows in a two-bank line memory and a 3x3
// window; it forms the neighbor sums and the neighbor count and pushes a job
// into a four-entry queue. The back part divides by the count with a
// restoring divider, one quotient bit per cycle for all channels at once.
// Border pixels produce no job. The back part works on one job at a time: it
// takes a new job only after the result of the last one has left, and a grown
// pixel first runs the serial divide. After reset the line memory is cleared,
// one entry a cycle, all MAX_PADDED_SIDE (1024) entries, while in_tready is
// low. A stalled receiver holds the result; the queue fills and then in_tready
// drops.
// A configuration write restarts the frame; stored rows are kept.
module masked_neighbor_average_grow #(
  parameter int MAX_PADDED_SIDE = mnag_pkg::MAX_PADDED_SIDE_D,
  parameter int SAMPLE_BITS     = mnag_pkg::SAMPLE_BITS_D,
  parameter int MAX_CHANNELS    = mnag_pkg::MAX_CHANNELS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [mnag_pkg::CFG_W-1:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // chan0, chan1, chan2, chan3
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // res0..res3, grown_total, pad
  output logic        out_tuser,  // was_grown
  output logic        out_tlast   // frame_end
);
  import mnag_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + 4;
  localparam int JOB_W = MAX_CHANNELS*SUM_W + MAX_CHANNELS*SAMPLE_BITS + 6;

  logic [SIDE_W-1:0]  side_r;
  logic [CHCNT_W-1:0] chcnt_r;
  logic restart;
  assign restart = cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r  <= SIDE_W'(1022);
      chcnt_r <= CHCNT_W'(4);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_SIDE:    side_r  <= cfg_data[SIDE_W-1:0];
        REG_CHANNEL_COUNT: chcnt_r <= cfg_data[CHCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [MAX_CHANNELS*SAMPLE_BITS-1:0] pix;
  always_comb
    for (int k = 0; k < MAX_CHANNELS; k++)
      pix[k*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'(in_tdata[k*16 +: 16]);

  logic fj_v, fj_r, bj_v, bj_r;
  logic [JOB_W-1:0] fj_d, bj_d;

  mnag_front #(.MAX_PADDED_SIDE(MAX_PADDED_SIDE), .SAMPLE_BITS(SAMPLE_BITS),
               .MAX_CHANNELS(MAX_CHANNELS), .SUM_W(SUM_W), .JOB_W(JOB_W)) u_front (
    .clk, .rst_n, .side_i(side_r), .chcnt_i(chcnt_r), .restart_i(restart),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_pix(pix),
    .job_valid(fj_v), .job_ready(fj_r), .job_data(fj_d));

  // border-free job filter: only emitting jobs enter the queue
  logic q_wv, q_wr;
  assign q_wv = fj_v && fj_d[JOB_W-1];
  assign fj_r = !fj_d[JOB_W-1] || q_wr;

  mnag_fifo #(.W(JOB_W), .DEPTH(4)) u_fifo (
    .clk, .rst_n, .wr_valid(q_wv), .wr_ready(q_wr), .wr_data(fj_d),
    .rd_valid(bj_v), .rd_ready(bj_r), .rd_data(bj_d));

  logic [MAX_CHANNELS*OUT_W-1:0] res;
  logic grown, last;
  logic [COUNT_W-1:0] total;

  mnag_back #(.SAMPLE_BITS(SAMPLE_BITS), .MAX_CHANNELS(MAX_CHANNELS),
              .SUM_W(SUM_W), .JOB_W(JOB_W)) u_back (
    .clk, .rst_n, .restart_i(restart), .ch_i(chcnt_r),
    .job_valid(bj_v), .job_ready(bj_r), .job_data(bj_d),
    .out_tvalid, .out_tready, .res_o(res), .grown_o(grown), .total_o(total),
    .last_o(last));

  always_comb begin
    out_tdata = '0;
    out_tdata[MAX_CHANNELS*OUT_W-1:0] = res;
    out_tdata[83:64] = total;
  end
  assign out_tuser = grown;
  assign out_tlast = last;

  a_grow_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[83:64] != '0)
    else $error("grown pixel with zero total");
  a_cov_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped");
  a_no_in_while_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_tready)
    else $error("input taken during clearing pass");
endmodule

/* design/mnag_front.sv */
// Front part: line buffer, 3x3 window and neighbor sums.
// Depends on mnag_pkg. Emits one job per interior pixel.
module mnag_front #(
  parameter int MAX_PADDED_SIDE = mnag_pkg::MAX_PADDED_SIDE_D,
  parameter int SAMPLE_BITS     = mnag_pkg::SAMPLE_BITS_D,
  parameter int MAX_CHANNELS    = mnag_pkg::MAX_CHANNELS_D,
  parameter int SUM_W           = SAMPLE_BITS + 4,
  parameter int JOB_W           = MAX_CHANNELS*SUM_W + MAX_CHANNELS*SAMPLE_BITS + 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [9:0]           side_i,
  input  logic [2:0]           chcnt_i,
  input  logic                 restart_i,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MAX_CHANNELS*SAMPLE_BITS-1:0] in_pix,
  output logic                 job_valid,
  input  logic                 job_ready,
  output logic [JOB_W-1:0]     job_data
);
  import mnag_pkg::*;

  localparam int PIX_W = MAX_CHANNELS*SAMPLE_BITS;
  localparam int AW    = $clog2(MAX_PADDED_SIDE);
  localparam int PW    = $clog2(MAX_PADDED_SIDE+1);

  logic [PIX_W-1:0] mem0 [MAX_PADDED_SIDE];
  logic [PIX_W-1:0] mem1 [MAX_PADDED_SIDE];

  // clearing pass
  logic [AW:0]  clr_r, clr_nxt;
  logic         clearing;
  assign clearing = (clr_r != AW'(0) + (AW+1)'(MAX_PADDED_SIDE)) ;

  logic [PW-1:0] row_r, col_r, row_nxt, col_nxt, pad;
  logic [PW-1:0] side_c;
  logic [2:0]    ch;
  always_comb begin
    side_c = (PW'(side_i) > PW'(MAX_PADDED_SIDE-2)) ? PW'(MAX_PADDED_SIDE-2) : PW'(side_i);
    pad = side_c + PW'(2);
    ch = (chcnt_i == 3'd0) ? 3'd1 :
         (chcnt_i > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : chcnt_i;
  end

  // stage A: read rows; stage B: window shift and sums
  logic             a_v_r;
  logic [PIX_W-1:0] a_cur_r, top_q, mid_q;
  logic             a_emit_r, a_last_r;
  logic             b_v_r;
  logic [PIX_W-1:0] win_r [3][3];
  logic             b_emit_r, b_last_r;

  logic stall;
  assign stall = b_v_r && !job_ready;
  assign in_ready = !clearing && !stall && !restart_i;

  logic acc;
  assign acc = in_valid && in_ready;

  logic [PW-1:0] r_eff, c_eff;
  logic [PIX_W-1:0] cur;
  always_comb begin
    r_eff = (row_r >= pad || col_r >= pad) ? '0 : row_r;
    c_eff = (row_r >= pad || col_r >= pad) ? '0 : col_r;
    for (int k = 0; k < MAX_CHANNELS; k++)
      cur[k*SAMPLE_BITS +: SAMPLE_BITS] = (k < int'(ch)) ? in_pix[k*SAMPLE_BITS +: SAMPLE_BITS]
                                                          : '0;
    col_nxt = c_eff + PW'(1);
    row_nxt = r_eff;
    if (col_nxt >= pad) begin
      col_nxt = '0;
      row_nxt = r_eff + PW'(1);
      if (row_nxt >= pad) row_nxt = '0;
    end
    clr_nxt = clearing ? clr_r + 1'b1 : clr_r;
  end

  // row r-2 lives in bank r&1; it is read then overwritten with cur
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem0[clr_r[AW-1:0]] <= '0;
      mem1[clr_r[AW-1:0]] <= '0;
    end else if (acc) begin
      if (r_eff[0]) mem1[c_eff[AW-1:0]] <= cur;
      else          mem0[c_eff[AW-1:0]] <= cur;
      top_q <= r_eff[0] ? mem1[c_eff[AW-1:0]] : mem0[c_eff[AW-1:0]];
      mid_q <= r_eff[0] ? mem0[c_eff[AW-1:0]] : mem1[c_eff[AW-1:0]];
      a_cur_r  <= cur;
      a_emit_r <= (r_eff >= PW'(2)) && (c_eff >= PW'(2));
      a_last_r <= (r_eff == pad - PW'(1)) && (c_eff == pad - PW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      row_r <= '0;
      col_r <= '0;
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      for (int y = 0; y < 3; y++)
        for (int x = 0; x < 3; x++) win_r[y][x] <= '0;
    end else begin
      clr_r <= clr_nxt;
      if (restart_i) begin
        row_r <= '0;
        col_r <= '0;
      end else if (acc) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (!stall) begin
        a_v_r <= acc;
        b_v_r <= a_v_r && a_emit_r;
        if (a_v_r) begin
          for (int y = 0; y < 3; y++) begin
            win_r[y][0] <= win_r[y][1];
            win_r[y][1] <= win_r[y][2];
          end
          win_r[0][2] <= top_q;
          win_r[1][2] <= mid_q;
          win_r[2][2] <= a_cur_r;
          b_emit_r <= a_emit_r;
          b_last_r <= a_last_r;
        end
      end
    end
  end

  // sums over the held window
  logic [SUM_W-1:0] sum [MAX_CHANNELS];
  logic [3:0]       cnt;
  logic [PIX_W-1:0] ctr;
  logic             ctr_empty;
  logic [1:0]       cov;
  always_comb begin
    cov = 2'(ch - 3'd1);
    ctr = win_r[1][1];
    ctr_empty = (ctr[cov*SAMPLE_BITS +: SAMPLE_BITS] == '0);
    cnt = '0;
    for (int k = 0; k < MAX_CHANNELS; k++)
      sum[k] = SUM_W'(ctr[k*SAMPLE_BITS +: SAMPLE_BITS]);
    for (int y = 0; y < 3; y++)
      for (int x = 0; x < 3; x++)
        if (!(y == 1 && x == 1) && win_r[y][x][cov*SAMPLE_BITS +: SAMPLE_BITS] != '0) begin
          cnt = cnt + 4'd1;
          for (int k = 0; k < MAX_CHANNELS; k++)
            if (k < int'(cov)) sum[k] = sum[k] + SUM_W'(win_r[y][x][k*SAMPLE_BITS +: SAMPLE_BITS]);
        end
    if (!ctr_empty) cnt = '0;
    for (int k = 0; k < MAX_CHANNELS; k++)
      job_data[k*SUM_W +: SUM_W] = sum[k];
    job_data[MAX_CHANNELS*SUM_W +: PIX_W] = ctr;
    job_data[JOB_W-6 +: 4] = cnt;
    job_data[JOB_W-2] = b_last_r;
    job_data[JOB_W-1] = b_emit_r;
  end
  assign job_valid = b_v_r;

endmodule

/* design/mnag_fifo.sv */
// Short queue between front and back parts.
// Depends on mnag_pkg for nothing but house style.
module mnag_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  import mnag_pkg::*;
  localparam int AW = $clog2(DEPTH);
  logic [W-1:0]  q_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   n_r;
  logic wr, rd;
  assign wr_ready = (n_r != (AW+1)'(DEPTH));
  assign rd_valid = (n_r != '0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = q_r[rp_r];
  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= wr_data;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; n_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      n_r <= n_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

/* design/mnag_back.sv */
// Back part: serial divide by the neighbor count, saturate, count grown.
// Depends on mnag_pkg.
module mnag_back #(
  parameter int SAMPLE_BITS  = mnag_pkg::SAMPLE_BITS_D,
  parameter int MAX_CHANNELS = mnag_pkg::MAX_CHANNELS_D,
  parameter int SUM_W        = SAMPLE_BITS + 4,
  parameter int JOB_W        = MAX_CHANNELS*SUM_W + MAX_CHANNELS*SAMPLE_BITS + 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             restart_i,
  input  logic [2:0]       ch_i,
  input  logic             job_valid,
  output logic             job_ready,
  input  logic [JOB_W-1:0] job_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [MAX_CHANNELS*mnag_pkg::OUT_W-1:0] res_o,
  output logic             grown_o,
  output logic [mnag_pkg::COUNT_W-1:0] total_o,
  output logic             last_o
);
  import mnag_pkg::*;
  localparam int SW = $clog2(SUM_W+1);

  div_state_t st_r, st_nxt;
  logic [SUM_W-1:0] q_r [MAX_CHANNELS];
  logic [3:0]       rem_r [MAX_CHANNELS];
  logic [3:0]       d_r;
  logic [SW-1:0]    step_r;
  logic [SAMPLE_BITS*MAX_CHANNELS-1:0] ctr_r;
  logic             last_r;
  logic             grow;
  logic [COUNT_W-1:0] cnt_r;
  logic [1:0]       cov;
  assign cov = 2'((ch_i == 3'd0) ? 3'd0 : (ch_i > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS-1)
                                                               : ch_i - 3'd1);

  always_comb begin
    st_nxt = st_r;
    job_ready = 1'b0;
    unique case (st_r)
      DIV_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) st_nxt = (job_data[JOB_W-6 +: 4] != '0) ? DIV_RUN : DIV_DONE;
      end
      DIV_RUN:  if (step_r == SW'(1)) st_nxt = DIV_DONE;
      DIV_DONE: if (out_tready) st_nxt = DIV_IDLE;
      default:  st_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= DIV_IDLE;
    else        st_r <= st_nxt;
  end

  // restoring division, one quotient bit per cycle on each channel
  logic [4:0] trial [MAX_CHANNELS];
  always_comb
    for (int k = 0; k < MAX_CHANNELS; k++)
      trial[k] = {rem_r[k], q_r[k][SUM_W-1]};

  always_ff @(posedge clk) begin
    if (st_r == DIV_IDLE && job_valid) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        q_r[k] <= job_data[k*SUM_W +: SUM_W];
        rem_r[k] <= '0;
      end
      ctr_r  <= job_data[MAX_CHANNELS*SUM_W +: SAMPLE_BITS*MAX_CHANNELS];
      d_r    <= job_data[JOB_W-6 +: 4];
      last_r <= job_data[JOB_W-2];
      step_r <= SW'(SUM_W);
    end else if (st_r == DIV_RUN) begin
      for (int k = 0; k < MAX_CHANNELS; k++) begin
        if (trial[k] >= {1'b0, d_r}) begin
          rem_r[k] <= 4'(trial[k] - {1'b0, d_r});
          q_r[k]   <= {q_r[k][SUM_W-2:0], 1'b1};
        end else begin
          rem_r[k] <= trial[k][3:0];
          q_r[k]   <= {q_r[k][SUM_W-2:0], 1'b0};
        end
      end
      step_r <= step_r - SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart_i) begin
      cnt_r <= '0;
    end else if (st_r == DIV_IDLE && job_valid) begin
      if (job_data[JOB_W-6 +: 4] != '0) cnt_r <= cnt_r + 1'b1;
    end else if (st_r == DIV_DONE && out_tready && last_r) begin
      cnt_r <= '0;
    end
  end

  always_comb begin
    grow = (d_r != '0);
    for (int k = 0; k < MAX_CHANNELS; k++) begin
      if (grow && k < int'(cov))
        res_o[k*OUT_W +: OUT_W] = (q_r[k] > SUM_W'({SAMPLE_BITS{1'b1}}))
                                   ? OUT_W'({SAMPLE_BITS{1'b1}})
                                   : OUT_W'(q_r[k]);
      else
        res_o[k*OUT_W +: OUT_W] = OUT_W'(ctr_r[k*SAMPLE_BITS +: SAMPLE_BITS]);
    end
  end
  assign out_tvalid = (st_r == DIV_DONE);
  assign grown_o = grow;
  assign total_o = cnt_r;
  assign last_o  = last_r;
endmodule
